@@ src/rsmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rsmp_pkg;

   // default reservoir depth
   localparam int RES_DEPTH_DEF = 32;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int RANDOM_W = 31;
   localparam int COUNT_W  = 32;
   localparam int SIZE_W   = 6;
   localparam int SLOT_W   = 5;

   // packed stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   // sample size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   // result of the shared remainder unit
   typedef struct packed {
      logic               done;
      logic [COUNT_W:0]   rem;
   } div_res_type;

endpackage

`default_nettype wire

@@ src/rsmp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ src/rsmp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsmp_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [rsmp_pkg::RANDOM_W-1:0]   dividend,
   input  wire logic [rsmp_pkg::COUNT_W:0]      divisor,
   output rsmp_pkg::div_res_type                res
);

   localparam int STEPS = rsmp_pkg::RANDOM_W;
   localparam int CW    = $clog2(STEPS);
   localparam int RW    = rsmp_pkg::COUNT_W + 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [STEPS-1:0]  dvd_ff, dvd_in;
   logic [RW-1:0]     div_ff, div_in;
   logic [RW:0]       trial;

   // one restoring step a cycle, dividend bits taken from the top
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff, dvd_ff[STEPS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = RW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[RW-1:0];
         end
         dvd_in = {dvd_ff[STEPS-2:0], 1'b0};
         cnt_in = CW'(cnt_ff + CW'(1));
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign res.done = done_ff;
   assign res.rem  = rem_ff;

   // finished remainder lies below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   // done is a single pulse after the run
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

endmodule

`default_nettype wire

@@ src/reservoir_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: sample_value, random_word; tlast: end_of_stream
// rsp_      out  rsp_tvalid/rsp_tready  tdata: kept_value, slot_index; tlast: last_of_run
// csr_      in   csr_we                 csr_wdata: sample_size
//
// an item whose count is below k goes straight to COMMIT; a replacement item first waits in DIVIDE
// for the shared remainder unit, which resolves one dividend bit a cycle.
// an end of stream item is followed by a drain of k slots, each paced by the
// registered read of the slot memory through DRAIN_RD and DRAIN_OUT.
// synchronous reset empties the reservoir at once through per-slot valid bits.
// req_tready is low while an item or a drain is in progress; rsp stalls hold.

module reservoir_sampler #(
   parameter int RES_DEPTH = rsmp_pkg::RES_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] sample_value, [62:32] random_word, [63] zero
   input  wire logic [rsmp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // end_of_stream
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] kept_value, [36:32] slot_index, [39:37] zero
   output logic      [rsmp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // last_of_run
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [rsmp_pkg::SIZE_W-1:0]       csr_wdata
);

   localparam int AW  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
   localparam int KW  = $clog2(RES_DEPTH + 1);
   localparam int VW  = rsmp_pkg::VALUE_W;
   localparam int CNW = rsmp_pkg::COUNT_W;
   localparam int SW  = rsmp_pkg::SIZE_W;

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      COMMIT,
      DRAIN_RD,
      DRAIN_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [SW-1:0]           size_ff;
   logic [VW-1:0]           value_ff, value_in;
   logic                    eos_ff, eos_in;
   logic [AW-1:0]           slot_ff, slot_in;
   logic                    wr_ok_ff, wr_ok_in;
   logic [CNW-1:0]          items_ff, items_in;
   logic [KW-1:0]           drain_ff, drain_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [RES_DEPTH-1:0]    valid_ff, valid_in;

   logic [SW:0]             size_ext;
   logic [KW-1:0]           k_eff;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    is_last;
   logic                    div_start;
   rsmp_pkg::div_res_type   div_res;
   logic [VW-1:0]           ram_rdata;
   logic [VW-1:0]           kept;

   // sample size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= rsmp_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   // k clamped to 1..RES_DEPTH
   always_comb begin
      size_ext = {1'b0, size_ff};
      if (size_ext == '0) begin
         size_ext = (SW+1)'(1);
      end else if (size_ext > (SW+1)'(RES_DEPTH)) begin
         size_ext = (SW+1)'(RES_DEPTH);
      end
      k_eff = KW'(size_ext);
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = (state_ff == DRAIN_OUT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign is_last    = (KW'(drain_ff + KW'(1)) == k_eff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      eos_in      = eos_ff;
      slot_in     = slot_ff;
      wr_ok_in    = wr_ok_ff;
      items_in    = items_ff;
      drain_in    = drain_ff;
      rd_valid_in = rd_valid_ff;
      valid_in    = valid_ff;
      div_start   = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_xfer) begin
               value_in = req_tdata[VW-1:0];
               eos_in   = req_tlast;
               if (items_ff < CNW'(k_eff)) begin
                  slot_in  = items_ff[AW-1:0];
                  wr_ok_in = 1'b1;
                  state_in = COMMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = DIVIDE;
               end
            end
         end
         DIVIDE: begin
            if (div_res.done) begin
               wr_ok_in = (div_res.rem < (CNW+1)'(k_eff));
               slot_in  = div_res.rem[AW-1:0];
               state_in = COMMIT;
            end
         end
         COMMIT: begin
            if (wr_ok_ff) begin
               valid_in[slot_ff] = 1'b1;
            end
            if (items_ff != '1) begin
               items_in = CNW'(items_ff + CNW'(1));
            end
            drain_in = '0;
            state_in = eos_ff ? DRAIN_RD : IDLE;
         end
         DRAIN_RD: begin
            rd_valid_in = valid_ff[drain_ff[AW-1:0]];
            state_in    = DRAIN_OUT;
         end
         DRAIN_OUT: begin
            if (rsp_xfer) begin
               if (is_last) begin
                  valid_in = '0;
                  items_in = '0;
                  state_in = IDLE;
               end else begin
                  drain_in = KW'(drain_ff + KW'(1));
                  state_in = DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         items_ff <= '0;
         valid_ff <= '0;
         wr_ok_ff <= 1'b0;
         eos_ff   <= 1'b0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         items_ff <= items_in;
         valid_ff <= valid_in;
         wr_ok_ff <= wr_ok_in;
         eos_ff   <= eos_in;
         drain_ff <= drain_in;
      end
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      rd_valid_ff <= rd_valid_in;
   end

   // shared remainder unit: random_word mod (count + 1)
   rsmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[VW +: rsmp_pkg::RANDOM_W]),
      .divisor  ((CNW+1)'({1'b0, items_ff} + (CNW+1)'(1))),
      .res      (div_res)
   );

   // slot memory
   rsmp_ram #(
      .WIDTH (VW),
      .DEPTH (RES_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    ((state_ff == COMMIT) && wr_ok_ff),
      .waddr (slot_ff),
      .wdata (value_ff),
      .raddr (drain_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // unwritten slots read as zero
   assign kept      = rd_valid_ff ? ram_rdata : '0;
   assign rsp_tdata = {{(rsmp_pkg::RSP_DATA_W - VW - rsmp_pkg::SLOT_W){1'b0}},
                       rsmp_pkg::SLOT_W'(drain_ff), kept};
   assign rsp_tlast = is_last;

   // no input transfer while a slot is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready during drain");

   // block goes busy after an input transfer
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("ready straight after an input transfer");

   // final slot transfer restarts the stream
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (items_ff == '0) && (valid_ff == '0))
      else $error("stream state not cleared after drain");

   // drain never runs past k
   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (drain_ff < k_eff))
      else $error("drain index beyond sample size");

endmodule

`default_nettype wire

@@ bench/reservoir_checker.sv @@
`timescale 1ns / 1ps

module reservoir_checker
   import rsmp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // [31:0] sample_value, [62:32] random_word, [63] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // end_of_stream
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] kept_value, [36:32] slot_index, [39:37] zero
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   // last_of_run
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [SIZE_W-1:0]     csr_wdata,
   output int                         error_count,
   output int                         drain_left
);

   localparam int DEPTH = RES_DEPTH_DEF;

   // one slot as it should leave the block during a drain
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [SLOT_W-1:0]  slot;
      logic               last;
   } slot_emit_type;

   logic [VALUE_W-1:0] sample_mem [DEPTH];
   logic [COUNT_W-1:0] items_seen;
   logic [SIZE_W-1:0]  size_reg;
   slot_emit_type      drain_q [$];
   int                 errors = 0;

   // slot count in force, raw register clamped to 1..DEPTH
   function automatic int unsigned slots_in_use(input logic [SIZE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > DEPTH) return DEPTH;
      return raw;
   endfunction

   // algorithm r step for one accepted item, queueing the drain on end of stream
   task automatic admit_sample(input logic [VALUE_W-1:0]  value,
                               input logic [RANDOM_W-1:0] rnd,
                               input logic                eos);
      int unsigned   k;
      logic [63:0]   pick;
      slot_emit_type e;
      k = slots_in_use(size_reg);
      if (items_seen < k) begin
         sample_mem[items_seen] = value;
      end else begin
         pick = {33'd0, rnd} % ({32'd0, items_seen} + 64'd1);
         if (pick < k) sample_mem[pick] = value;
      end
      if (items_seen != '1) items_seen++;
      if (eos) begin
         for (int unsigned s = 0; s < k; s++) begin
            e.value = sample_mem[s];
            e.slot  = s[SLOT_W-1:0];
            e.last  = (s + 1 == k);
            drain_q.push_back(e);
         end
         foreach (sample_mem[n]) sample_mem[n] = '0;
         items_seen = '0;
      end
   endtask

   always @(posedge clock) begin
      slot_emit_type e;
      if (reset) begin
         foreach (sample_mem[n]) sample_mem[n] = '0;
         items_seen = '0;
         size_reg   = SIZE_RESET;
         drain_q.delete();
      end else begin
         if (csr_we) size_reg = csr_wdata;
         // result transfer against the oldest expected slot
         if (rsp_tvalid && rsp_tready) begin
            if (drain_q.size() == 0) begin
               $error("rsp transfer with no slot expected: %h", rsp_tdata);
               errors++;
            end else begin
               e = drain_q.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== e.value) begin
                  $error("kept_value: expected %h, got %h", e.value,
                         rsp_tdata[VALUE_W-1:0]);
                  errors++;
               end
               if (rsp_tdata[VALUE_W +: SLOT_W] !== e.slot) begin
                  $error("slot_index: expected %0d, got %0d", e.slot,
                         rsp_tdata[VALUE_W +: SLOT_W]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_of_run: expected %b, got %b", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            admit_sample(req_tdata[VALUE_W-1:0], req_tdata[VALUE_W +: RANDOM_W], req_tlast);
      end
      error_count <= errors;
      drain_left  <= drain_q.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rsmp_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   // long enough for a replacement item still in flight to finish
   localparam int QUIET_CYCLES = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata = '0;
   int                    error_count;
   int                    drain_left;

   bit          steady = 1'b0;
   bit          hold_req = 1'b0;
   int unsigned items_sent = 0;
   int unsigned cycles = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   reservoir_sampler #(.RES_DEPTH(RES_DEPTH_DEF)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   reservoir_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .drain_left  (drain_left)
   );

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RANDOM_W-1:0] rand_word();
      logic [31:0] w;
      case ($urandom_range(0, 7))
         0:       w = '0;
         1:       w = 32'h7fff_ffff;
         2:       w = $urandom_range(0, 15);
         default: w = $urandom;
      endcase
      return w[RANDOM_W-1:0];
   endfunction

   // offer one item after a random gap and hold it until the transfer
   task automatic send_item(input logic [VALUE_W-1:0]  value,
                            input logic [RANDOM_W-1:0] rnd,
                            input logic                eos);
      int g;
      g = steady ? 0 : gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rnd, value};
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_stream(input int len, input bit with_eos);
      for (int n = 0; n < len; n++)
         send_item(rand_value(), rand_word(), with_eos && (n == len - 1));
   endtask

   // stop offering, wait for every expected slot, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drain_left != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] sz);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sz;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = gap_len();
         end
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int sz, kk, nstreams, len, phase;
      bit eos;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single slot, one item that is also the end of stream, extreme fields
      write_size(6'd1);
      send_item(32'h8000_0000, 31'h7fff_ffff, 1'b1);
      send_item(32'h7fff_ffff, 31'h0, 1'b0);
      send_item(32'hffff_ffff, 31'h7fff_ffff, 1'b0);
      send_item(32'h0000_0000, 31'h1, 1'b1);

      // size zero acts as one slot
      settle();
      write_size(6'd0);
      send_item(32'h0000_1234, 31'h0, 1'b0);
      send_item(32'hffff_fffb, 31'h2, 1'b1);

      // size above depth clamps, short stream leaves zero slots
      settle();
      write_size(6'h3f);
      send_item(32'haaaa_5555, 31'h5, 1'b0);
      send_item(32'h5555_aaaa, 31'h0, 1'b1);

      // size changed part way through a stream
      settle();
      write_size(6'd4);
      send_item(32'h0000_0011, 31'h0, 1'b0);
      send_item(32'h0000_0022, 31'h3, 1'b0);
      send_item(32'h0000_0033, 31'h4, 1'b0);
      send_item(32'h0000_0044, 31'h5, 1'b0);
      send_item(32'h0000_0055, 31'h2, 1'b0);
      send_item(32'h0000_0066, 31'h7fff_ffff, 1'b0);
      settle();
      write_size(6'd2);
      send_item(32'h0000_0077, 31'h1, 1'b0);
      send_item(32'h0000_0088, 31'h0, 1'b1);

      // full depth exactly
      settle();
      write_size(6'd32);
      send_item(32'hdead_beef, 31'h0, 1'b0);
      send_item(32'h8000_0001, 31'h4000_0000, 1'b0);
      send_item(32'h7fff_fffe, 31'h3fff_ffff, 1'b1);

      // random phases of whole streams, some left open across a size change
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0:       sz = 0;
            1:       sz = 63;
            2:       sz = 32;
            3:       sz = $urandom_range(33, 62);
            4:       sz = $urandom_range(9, 31);
            default: sz = $urandom_range(1, 8);
         endcase
         write_size(sz[SIZE_W-1:0]);
         kk = (sz == 0) ? 1 : ((sz > RES_DEPTH_DEF) ? RES_DEPTH_DEF : sz);
         steady = ($urandom_range(0, 3) == 0);
         nstreams = $urandom_range(1, 3);
         // long result stall while input keeps coming, so the block backs up
         if (phase == 1) begin
            hold_req = 1'b1;
            nstreams = 3;
         end
         for (int s = 0; s < nstreams; s++) begin
            len = $urandom_range(1, (kk < 12) ? 3 * kk + 2 : 40);
            if (phase == 1 && s == 0) len = 2;
            eos = !((s == nstreams - 1) && ($urandom_range(0, 4) == 0));
            send_stream(len, eos);
         end
         phase++;
      end
      steady = 1'b0;

      settle();
      if (error_count == 0 && drain_left == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
